[hdl/asd_pkg.sv]
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types and constants for the accelerometer shove detector.
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ELAPSED_W  = 12;
    localparam int TRIG_W     = 15;
    localparam int WEIGHT_W   = 8;
    localparam int CFG_TIME_W = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_TIME = 3'd4;

    localparam logic                  RST_DETECT_ENABLE = 1'b1;
    localparam logic [TRIG_W-1:0]     RST_TRIGGER_LEVEL = 15'd3482;
    localparam logic [WEIGHT_W-1:0]   RST_BLEND_WEIGHT  = 8'd31;
    localparam logic [CFG_TIME_W-1:0] RST_HOLD_TIME     = 12'd60;
    localparam logic [CFG_TIME_W-1:0] RST_COOLDOWN_TIME = 12'd280;

    localparam logic [1:0] DIR_LEFT   = 2'd0;
    localparam logic [1:0] DIR_RIGHT  = 2'd1;
    localparam logic [1:0] DIR_BOTTOM = 2'd2;

    typedef struct packed {
        logic [ELAPSED_W-1:0]       elapsed_ms;
        logic                       sample_valid;
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
    } t_in_beat;

    typedef struct packed {
        logic       release_valid;
        logic [1:0] release_dir;
        logic       press_valid;
        logic [1:0] press_dir;
    } t_out_beat;

    typedef struct packed {
        logic                  detect_enable;
        logic [TRIG_W-1:0]     trigger_level;
        logic [WEIGHT_W-1:0]   blend_weight;
        logic [CFG_TIME_W-1:0] hold_time_ms;
        logic [CFG_TIME_W-1:0] cooldown_time_ms;
    } t_cfg;

endpackage

[hdl/asd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// asd_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module asd_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [asd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [asd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output asd_pkg::t_cfg                   o_cfg
);

    asd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_enable    <= asd_pkg::RST_DETECT_ENABLE;
            r_cfg.trigger_level    <= asd_pkg::RST_TRIGGER_LEVEL;
            r_cfg.blend_weight     <= asd_pkg::RST_BLEND_WEIGHT;
            r_cfg.hold_time_ms     <= asd_pkg::RST_HOLD_TIME;
            r_cfg.cooldown_time_ms <= asd_pkg::RST_COOLDOWN_TIME;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                asd_pkg::CFG_DETECT_ENABLE: begin
                    r_cfg.detect_enable <= i_cfg_wdata[0];
                end
                asd_pkg::CFG_TRIGGER_LEVEL: begin
                    r_cfg.trigger_level <= i_cfg_wdata[asd_pkg::TRIG_W-1:0];
                end
                asd_pkg::CFG_BLEND_WEIGHT: begin
                    r_cfg.blend_weight <= i_cfg_wdata[asd_pkg::WEIGHT_W-1:0];
                end
                asd_pkg::CFG_HOLD_TIME: begin
                    r_cfg.hold_time_ms <= i_cfg_wdata[asd_pkg::CFG_TIME_W-1:0];
                end
                asd_pkg::CFG_COOLDOWN_TIME: begin
                    r_cfg.cooldown_time_ms <= i_cfg_wdata[asd_pkg::CFG_TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/asd_core.sv]
// ----------------------------------------------------------------------------
// asd_core
// Detector state, timers and the single-pass gravity blend / classification.
// ----------------------------------------------------------------------------
module asd_core #(
    parameter int GRAVITY_FRAC_BITS = 8,
    parameter int TIMER_WIDTH       = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  asd_pkg::t_in_beat   i_item,
    input  asd_pkg::t_cfg       i_cfg,
    output asd_pkg::t_out_beat  o_res
);

    localparam int S  = asd_pkg::SAMPLE_W;
    localparam int F  = GRAVITY_FRAC_BITS;
    localparam int T  = TIMER_WIDTH;
    localparam int G  = S + F;
    localparam int D  = G + 1;
    localparam int P  = D + asd_pkg::WEIGHT_W + 1;
    localparam int IW = G + 1;
    localparam int TF = asd_pkg::TRIG_W + F;
    localparam int CW = ((IW > TF) ? IW : TF) + 1;
    localparam int EW = asd_pkg::ELAPSED_W;
    localparam int LW = ((T > asd_pkg::CFG_TIME_W) ? T :
                         ((asd_pkg::CFG_TIME_W > EW) ? asd_pkg::CFG_TIME_W : EW)) + 1;

    localparam logic [LW-1:0] TMAX = {{(LW-T){1'b0}}, {T{1'b1}}};

    logic signed [G-1:0] r_grav_x, r_grav_y, n_grav_x, n_grav_y;
    logic                r_primed, n_primed;
    logic                r_holding, n_holding;
    logic [1:0]          r_held_dir, n_held_dir;
    logic [T-1:0]        r_hold_left, n_hold_left;
    logic [T-1:0]        r_cool_left, n_cool_left;

    function automatic logic [T-1:0] count_down(input logic [T-1:0] t,
                                                input logic [EW-1:0] e);
        logic [LW-1:0] t_w;
        logic [LW-1:0] e_w;
        logic [LW-1:0] d_w;
        t_w = {{(LW-T){1'b0}}, t};
        e_w = {{(LW-EW){1'b0}}, e};
        d_w = t_w - e_w;
        return (t_w > e_w) ? d_w[T-1:0] : '0;
    endfunction

    function automatic logic [T-1:0] timer_load(
            input logic [asd_pkg::CFG_TIME_W-1:0] v);
        logic [LW-1:0] v_w;
        v_w = {{(LW-asd_pkg::CFG_TIME_W){1'b0}}, v};
        return (v_w > TMAX) ? TMAX[T-1:0] : v_w[T-1:0];
    endfunction

    typedef struct packed {
        logic [IW-1:0]        mag;
        logic signed [IW-1:0] imp;
        logic signed [G-1:0]  g_new;
    } t_axis;

    function automatic t_axis blend_axis(input logic signed [G-1:0] fx,
                                         input logic signed [G-1:0] g,
                                         input logic [asd_pkg::WEIGHT_W-1:0] w);
        t_axis                 r;
        logic signed [D-1:0]   diff;
        logic signed [P-1:0]   prod;
        logic signed [G+1:0]   gsum;
        logic signed [IW-1:0]  imp;
        diff = {fx[G-1], fx} - {g[G-1], g};
        prod = $signed({{(P-D){diff[D-1]}}, diff}) *
               $signed({{(P-asd_pkg::WEIGHT_W){1'b0}}, w});
        gsum = {{2{g[G-1]}}, g} + prod[P-1:asd_pkg::WEIGHT_W];
        r.g_new = gsum[G-1:0];
        imp = {fx[G-1], fx} - {r.g_new[G-1], r.g_new};
        r.imp = imp;
        r.mag = imp[IW-1] ? (-imp) : imp;
        return r;
    endfunction

    logic                release_now;
    logic                hold_after;
    logic [T-1:0]        hold_cnt, cool_cnt;
    logic                detect;
    logic signed [G-1:0] fx, fy;
    t_axis               ax, ay;
    logic [CW-1:0]       thr_c, magx_c, magy_c;
    logic signed [CW-1:0] iy_c;
    logic                x_wins, y_wins, fire;
    logic [1:0]          dir;

    always_comb begin
        hold_cnt    = count_down(r_hold_left, i_item.elapsed_ms);
        release_now = r_holding && (hold_cnt == '0);
        hold_after  = r_holding && !release_now;
        cool_cnt    = (r_cool_left != '0) ? count_down(r_cool_left, i_item.elapsed_ms)
                                          : r_cool_left;
        detect = i_cfg.detect_enable && i_item.sample_valid && !hold_after &&
                 (cool_cnt == '0);

        fx = {i_item.accel_x, {F{1'b0}}};
        fy = {i_item.accel_y, {F{1'b0}}};
        ax = blend_axis(fx, r_grav_x, i_cfg.blend_weight);
        ay = blend_axis(fy, r_grav_y, i_cfg.blend_weight);

        thr_c  = {{(CW-TF){1'b0}}, i_cfg.trigger_level, {F{1'b0}}};
        magx_c = {{(CW-IW){1'b0}}, ax.mag};
        magy_c = {{(CW-IW){1'b0}}, ay.mag};
        iy_c   = {{(CW-IW){ay.imp[IW-1]}}, ay.imp};

        x_wins = (magx_c > thr_c) && (magx_c >= magy_c);
        y_wins = $signed(iy_c) > $signed(thr_c);
        fire   = detect && r_primed && (x_wins || y_wins);
        if (x_wins) begin
            dir = (!ax.imp[IW-1] && (ax.imp != '0)) ? asd_pkg::DIR_RIGHT
                                                      : asd_pkg::DIR_LEFT;
        end else if (y_wins) begin
            dir = asd_pkg::DIR_BOTTOM;
        end else begin
            dir = asd_pkg::DIR_LEFT;
        end

        o_res.release_valid = release_now;
        o_res.release_dir   = release_now ? r_held_dir : asd_pkg::DIR_LEFT;
        o_res.press_valid   = fire;
        o_res.press_dir     = fire ? dir : asd_pkg::DIR_LEFT;

        n_grav_x    = r_grav_x;
        n_grav_y    = r_grav_y;
        n_primed    = r_primed;
        n_holding   = hold_after;
        n_held_dir  = r_held_dir;
        n_hold_left = r_holding ? hold_cnt : r_hold_left;
        n_cool_left = cool_cnt;
        if (detect) begin
            n_primed = 1'b1;
            n_grav_x = r_primed ? ax.g_new : fx;
            n_grav_y = r_primed ? ay.g_new : fy;
        end
        if (fire) begin
            n_holding   = 1'b1;
            n_held_dir  = dir;
            n_hold_left = timer_load(i_cfg.hold_time_ms);
            n_cool_left = timer_load(i_cfg.cooldown_time_ms);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed    <= 1'b0;
            r_holding   <= 1'b0;
            r_held_dir  <= asd_pkg::DIR_LEFT;
            r_hold_left <= '0;
            r_cool_left <= '0;
        end else if (i_adv) begin
            r_primed    <= n_primed;
            r_holding   <= n_holding;
            r_held_dir  <= n_held_dir;
            r_hold_left <= n_hold_left;
            r_cool_left <= n_cool_left;
        end
    end

    // gravity is only read once primed
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_grav_x <= n_grav_x;
            r_grav_y <= n_grav_y;
        end
    end

    a_idle_timer_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_holding |-> (r_hold_left == '0))
        else $error("hold timer running with no bump held");

    a_release_needs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.release_valid) |-> r_holding)
        else $error("release without a held bump");

    a_press_needs_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.press_valid) |-> r_primed)
        else $error("press before gravity primed");

    a_press_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.press_valid) |=> (r_holding && (r_held_dir == $past(o_res.press_dir))))
        else $error("press did not start a hold");

endmodule

[hdl/accel_shove_detector_top.sv]
// ----------------------------------------------------------------------------
// accel_shove_detector_top
// Shove detector: input register, single-pass core, result register.
// ----------------------------------------------------------------------------
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+---------------------------
//  input    | i_in_valid  | o_in_stall   | i_in_data  (t_in_beat)
//  result   | o_out_valid | i_out_stall  | o_out_data (t_out_beat)
//  config   | i_cfg_we    | -            | i_cfg_idx, i_cfg_wdata
//
//  One beat per cycle sustained while the result is not stalled; each input
//  beat passes the input register, then the result register, and its result
//  is valid, and can be taken, once it is in the result register.
//  The core's state updates only when the input register advances.
//  Synchronous active-low reset clears control state and loads config defaults.
//  A stalled result holds the result register; the input register then holds
//  and o_in_stall rises.
// ----------------------------------------------------------------------------
module accel_shove_detector_top #(
    parameter int GRAVITY_FRAC_BITS = 8,
    parameter int TIMER_WIDTH       = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  asd_pkg::t_in_beat               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output asd_pkg::t_out_beat              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [asd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [asd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    asd_pkg::t_cfg      cfg;
    asd_pkg::t_out_beat res;
    asd_pkg::t_in_beat  r_in;
    asd_pkg::t_out_beat r_out;
    logic               r_in_v;
    logic               r_out_v;
    logic               adv;
    logic               take;

    assign adv        = r_in_v && (!r_out_v || !i_out_stall);
    assign o_in_stall = r_in_v && !adv;
    assign take       = i_in_valid && !o_in_stall;

    asd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    asd_core #(
        .GRAVITY_FRAC_BITS (GRAVITY_FRAC_BITS),
        .TIMER_WIDTH       (TIMER_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (take) begin
                r_in_v <= 1'b1;
            end else if (adv) begin
                r_in_v <= 1'b0;
            end
            if (adv) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

[tb/tb_accel_shove_detector_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_shove_detector_top
// Self-checking bench for the shove detector. A beat-level predictor follows
// gravity, hold and cooldown for every taken input beat and checks each
// result beat in order. A directed opening covers the extremes, then random
// traffic runs under several settings, all but one with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_accel_shove_detector_top;

    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_BEATS = 160;
    localparam logic [asd_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [asd_pkg::CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    class shove_tracker;
        logic                           en;
        logic [asd_pkg::TRIG_W-1:0]     trig;
        logic [asd_pkg::WEIGHT_W-1:0]   weight;
        logic [asd_pkg::CFG_TIME_W-1:0] hold_ms;
        logic [asd_pkg::CFG_TIME_W-1:0] cool_ms;
        logic signed [23:0]             grav_x;
        logic signed [23:0]             grav_y;
        bit                             primed;
        bit                             holding;
        logic [1:0]                     held_dir;
        logic [asd_pkg::CFG_TIME_W-1:0] hold_left;
        logic [asd_pkg::CFG_TIME_W-1:0] cool_left;
        asd_pkg::t_out_beat             expected_shoves[$];
        int                             errors;
        int                             beat_no;

        function new();
            en        = asd_pkg::RST_DETECT_ENABLE;
            trig      = asd_pkg::RST_TRIGGER_LEVEL;
            weight    = asd_pkg::RST_BLEND_WEIGHT;
            hold_ms   = asd_pkg::RST_HOLD_TIME;
            cool_ms   = asd_pkg::RST_COOLDOWN_TIME;
            grav_x    = '0;
            grav_y    = '0;
            primed    = 0;
            holding   = 0;
            held_dir  = asd_pkg::DIR_LEFT;
            hold_left = '0;
            cool_left = '0;
            errors    = 0;
            beat_no   = 0;
        endfunction

        function void write_reg(logic [asd_pkg::CFG_IDX_W-1:0] idx,
                                logic [asd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                asd_pkg::CFG_DETECT_ENABLE: en      = data[0];
                asd_pkg::CFG_TRIGGER_LEVEL: trig    = data[asd_pkg::TRIG_W-1:0];
                asd_pkg::CFG_BLEND_WEIGHT:  weight  = data[asd_pkg::WEIGHT_W-1:0];
                asd_pkg::CFG_HOLD_TIME:     hold_ms = data[asd_pkg::CFG_TIME_W-1:0];
                asd_pkg::CFG_COOLDOWN_TIME: cool_ms = data[asd_pkg::CFG_TIME_W-1:0];
                default: ;
            endcase
        endfunction

        // g += floor((f - g) * w / 256)
        function logic signed [23:0] blend(logic signed [23:0] g, logic signed [23:0] f);
            longint d;
            longint r;
            d = (longint'(f) - longint'(g)) * longint'(weight);
            r = longint'(g) + (d >>> 8);
            return r[23:0];
        endfunction

        function void predict_shove(asd_pkg::t_in_beat b);
            asd_pkg::t_out_beat r;
            logic signed [23:0] fx;
            logic signed [23:0] fy;
            longint             ix, iy, ax, ay, thr;
            logic [1:0]         dir;
            bit                 fire;
            r = '0;
            if (holding) begin
                hold_left = (hold_left > b.elapsed_ms) ? hold_left - b.elapsed_ms : '0;
                if (hold_left == 0) begin
                    holding         = 0;
                    r.release_valid = 1'b1;
                    r.release_dir   = held_dir;
                end
            end
            if (cool_left != 0)
                cool_left = (cool_left > b.elapsed_ms) ? cool_left - b.elapsed_ms : '0;
            if (en && b.sample_valid && !holding && cool_left == 0) begin
                fx = {b.accel_x, 8'd0};
                fy = {b.accel_y, 8'd0};
                if (!primed) begin
                    grav_x = fx;
                    grav_y = fy;
                    primed = 1;
                end else begin
                    grav_x = blend(grav_x, fx);
                    grav_y = blend(grav_y, fy);
                    ix   = longint'(fx) - longint'(grav_x);
                    iy   = longint'(fy) - longint'(grav_y);
                    ax   = (ix < 0) ? -ix : ix;
                    ay   = (iy < 0) ? -iy : iy;
                    thr  = longint'(trig) << 8;
                    fire = 1;
                    dir  = asd_pkg::DIR_LEFT;
                    if (ax > thr && ax >= ay)
                        dir = (ix > 0) ? asd_pkg::DIR_RIGHT : asd_pkg::DIR_LEFT;
                    else if (iy > thr)
                        dir = asd_pkg::DIR_BOTTOM;
                    else
                        fire = 0;
                    if (fire) begin
                        r.press_valid = 1'b1;
                        r.press_dir   = dir;
                        held_dir      = dir;
                        holding       = 1;
                        hold_left     = hold_ms;
                        cool_left     = cool_ms;
                    end
                end
            end
            expected_shoves.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH beat %0d: %s", beat_no, msg);
            errors++;
        endtask

        task check_shove(asd_pkg::t_out_beat got);
            asd_pkg::t_out_beat want;
            if (expected_shoves.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
                beat_no++;
                return;
            end
            want = expected_shoves.pop_front();
            if (got.release_valid !== want.release_valid)
                report_mismatch($sformatf("release_valid %b, want %b",
                                          got.release_valid, want.release_valid));
            if (got.release_dir !== want.release_dir)
                report_mismatch($sformatf("release_dir %0d, want %0d",
                                          got.release_dir, want.release_dir));
            if (got.press_valid !== want.press_valid)
                report_mismatch($sformatf("press_valid %b, want %b",
                                          got.press_valid, want.press_valid));
            if (got.press_dir !== want.press_dir)
                report_mismatch($sformatf("press_dir %0d, want %0d",
                                          got.press_dir, want.press_dir));
            beat_no++;
        endtask
    endclass

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    asd_pkg::t_in_beat              i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    asd_pkg::t_out_beat             o_out_data;
    logic                           i_cfg_we    = 1'b0;
    logic [asd_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [asd_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    bit           gaps_on = 1'b1;
    shove_tracker sb      = new();

    accel_shove_detector_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(99) < 14);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.predict_shove(i_in_data);
            if (o_out_valid && !i_out_stall)
                sb.check_shove(o_out_data);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("accel_shove_detector_top verification failed");
        $finish;
    end

    function automatic logic [asd_pkg::SAMPLE_W-1:0] clamp16(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return 16'h8000;
        return v[asd_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic asd_pkg::t_in_beat make_beat(int el, bit v, int x, int y);
        asd_pkg::t_in_beat b;
        b.elapsed_ms   = el[asd_pkg::ELAPSED_W-1:0];
        b.sample_valid = v;
        b.accel_x      = clamp16(x);
        b.accel_y      = clamp16(y);
        return b;
    endfunction

    // Mostly readings at rest about (bx, by), some shoves, some noise.
    function automatic asd_pkg::t_in_beat random_beat(int bx, int by);
        int pick, kind, el, x, y, mag;
        bit v;
        pick = $urandom_range(99);
        if (pick < 60)
            el = $urandom_range(20);
        else if (pick < 85)
            el = $urandom_range(300, 21);
        else if (pick < 97)
            el = $urandom_range(4095);
        else
            el = pick[0] ? 4095 : 0;
        kind = $urandom_range(99);
        v    = 1'b1;
        x    = bx + int'($urandom_range(600)) - 300;
        y    = by + int'($urandom_range(600)) - 300;
        if (kind >= 55 && kind < 78) begin
            mag = $urandom_range(30000, 1000);
            case ($urandom_range(3))
                0: x = x + mag;
                1: x = x - mag;
                2: y = y + mag;
                default: y = y - mag;
            endcase
        end else if (kind >= 78) begin
            x = int'($urandom_range(65535)) - 32768;
            y = int'($urandom_range(65535)) - 32768;
            v = (kind < 88) ? 1'($urandom_range(1)) : 1'b0;
        end
        return make_beat(el, v, x, y);
    endfunction

    task automatic send_beat(input asd_pkg::t_in_beat b);
        while (gaps_on && $urandom_range(99) < 14) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.expected_shoves.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [asd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [asd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic cfg_close();
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic en,
                                  input logic [asd_pkg::TRIG_W-1:0] trig,
                                  input logic [asd_pkg::WEIGHT_W-1:0] wt,
                                  input logic [asd_pkg::CFG_TIME_W-1:0] hold,
                                  input logic [asd_pkg::CFG_TIME_W-1:0] cool);
        cfg_write(asd_pkg::CFG_DETECT_ENABLE, asd_pkg::CFG_DATA_W'(en));
        cfg_write(asd_pkg::CFG_TRIGGER_LEVEL, asd_pkg::CFG_DATA_W'(trig));
        cfg_write(asd_pkg::CFG_BLEND_WEIGHT, asd_pkg::CFG_DATA_W'(wt));
        cfg_write(asd_pkg::CFG_HOLD_TIME, asd_pkg::CFG_DATA_W'(hold));
        cfg_write(asd_pkg::CFG_COOLDOWN_TIME, asd_pkg::CFG_DATA_W'(cool));
        cfg_close();
    endtask

    initial begin
        int ph;
        int n;
        int bx, by;
        int gx8, gy8;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: prime, equal-axis tie, hold, release, cooldown
        send_beat(make_beat(0, 0, 32767, -32768));
        send_beat(make_beat(0, 1, 0, 0));
        send_beat(make_beat(5, 1, 20000, 20000));
        send_beat(make_beat(0, 1, -32768, 32767));
        send_beat(make_beat(60, 1, 0, 0));
        send_beat(make_beat(219, 1, 0, 0));
        send_beat(make_beat(1, 1, -32768, 0));
        send_beat(make_beat(4095, 1, 0, 32767));
        send_beat(make_beat(4095, 1, 0, -32768));
        send_beat(make_beat(4095, 0, 0, 0));
        drain_results();

        // masked enable write, spare indexes must be ignored
        cfg_write(asd_pkg::CFG_DETECT_ENABLE, 15'h7FFE);
        cfg_write(CFG_SPARE_FIRST, 15'h7FFF);
        cfg_write(CFG_SPARE_LAST, 15'h1234);
        cfg_close();
        send_beat(make_beat(0, 1, 32767, 32767));
        drain_results();

        // frozen gravity, threshold edges, zero hold and cooldown
        apply_settings(1'b1, 15'd1000, 8'd0, 12'd0, 12'd0);
        gx8 = int'(sb.grav_x >>> 8);
        gy8 = int'(sb.grav_y >>> 8);
        send_beat(make_beat(0, 1, gx8 + 1000, gy8));
        send_beat(make_beat(0, 1, gx8 + 1001, gy8));
        send_beat(make_beat(0, 1, gx8 - 1001, gy8));
        send_beat(make_beat(0, 1, gx8, gy8 + 1001));
        send_beat(make_beat(0, 1, gx8, gy8 - 2000));
        drain_results();

        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0: apply_settings(1'b1, asd_pkg::RST_TRIGGER_LEVEL,
                                  asd_pkg::RST_BLEND_WEIGHT,
                                  asd_pkg::RST_HOLD_TIME,
                                  asd_pkg::RST_COOLDOWN_TIME);
                1: apply_settings(1'b1, 15'd0, 8'd0, 12'd0, 12'd0);
                2: apply_settings(1'b1, 15'd32767, 8'd255, 12'd4095, 12'd4095);
                3: apply_settings(1'b1, 15'd1500, 8'd200, 12'd15, 12'd40);
                4: apply_settings(1'b0, 15'd800, 8'd64, 12'd30, 12'd90);
                default: apply_settings(1'($urandom_range(9) != 0),
                                        asd_pkg::TRIG_W'($urandom_range(6000)),
                                        asd_pkg::WEIGHT_W'($urandom_range(255)),
                                        asd_pkg::CFG_TIME_W'($urandom_range(120)),
                                        asd_pkg::CFG_TIME_W'($urandom_range(400)));
            endcase
            gaps_on = (ph != 3);
            bx = int'($urandom_range(16000)) - 8000;
            by = int'($urandom_range(16000)) - 8000;
            for (n = 0; n < PHASE_BEATS; n++)
                send_beat(random_beat(bx, by));
            drain_results();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("accel_shove_detector_top verification clean");
        else
            $display("accel_shove_detector_top verification failed");
        $finish;
    end

endmodule
